// ----- src/lgt_pkg.sv -----
// Shared types and constants for the luma gradient tint pixel core.
// No dependencies; imported by luma_gradient_tint_pixel_core.
package lgt_pkg;

  // Q16 luma weights, summing to 65536
  localparam logic [15:0] LumaWb = 16'd7471;
  localparam logic [15:0] LumaWg = 16'd38470;
  localparam logic [15:0] LumaWr = 16'd19595;

  // Q8 full tint
  localparam logic [8:0] AmountFull = 9'd256;

  localparam int unsigned NumChan = 3;
  localparam int unsigned ChanBlue = 0;
  localparam int unsigned ChanGreen = 1;
  localparam int unsigned ChanRed = 2;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 9;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegBlackRed   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBlackGreen = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBlackBlue  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWhiteRed   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWhiteGreen = 3'd4;
  localparam logic [CfgIdxW-1:0] RegWhiteBlue  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegTintAmount = 3'd6;

  // Reset values
  localparam logic [7:0] BlackRst = 8'd0;
  localparam logic [7:0] WhiteRedRst = 8'd128;
  localparam logic [7:0] WhiteGreenRst = 8'd255;
  localparam logic [7:0] WhiteBlueRst = 8'd128;
  localparam logic [8:0] TintRst = 9'd64;

  // Pipeline depth, input register to output register
  localparam int unsigned NumStages = 7;

  // Pixel sideband carried down the pipeline
  typedef struct packed {
    logic [NumChan-1:0][7:0] col;
    logic [7:0]              alpha;
    logic                    frame_end;
  } pix_t;

endpackage

// ----- src/luma_gradient_tint_pixel_core.sv -----
// Luma gradient-map tint core: seven-stage pixel pipeline with config registers.
// Depends on lgt_pkg for constants and the pixel sideband type.

// One pixel enters each clock: a beat is taken whenever start_i is high, and
// busy_o stays low, so the source never waits. The result beat shows up on the
// out_*_o ports from the output register, marked by a one-cycle
// out_valid_o strobe; the receiver cannot stall, so it must take every strobed
// beat. The seven register stages are luma products, luma sum, gradient
// product, divide by 255, gradient clamp, blend products and blend sum.
// Write configuration only while no beat is in flight: the stages read the
// registers directly.
module luma_gradient_tint_pixel_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [7:0]                  in_blue_i,
  input  logic [7:0]                  in_green_i,
  input  logic [7:0]                  in_red_i,
  input  logic [7:0]                  in_alpha_i,
  input  logic                        in_frame_end_i,
  input  logic                        cfg_we_i,
  input  logic [lgt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lgt_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                        out_valid_o,
  output logic [7:0]                  out_blue_o,
  output logic [7:0]                  out_green_o,
  output logic [7:0]                  out_red_o,
  output logic [7:0]                  out_alpha_o,
  output logic                        out_frame_end_o
);
  import lgt_pkg::*;

  // never stall the source
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------------
  // Configuration registers, per channel (blue, green, red)
  // ---------------------------------------------------------------------------
  logic [NumChan-1:0][7:0] blk_q, blk_d;
  logic [NumChan-1:0][7:0] wht_q, wht_d;
  logic [8:0]              tint_q, tint_d;

  always_comb begin
    blk_d  = blk_q;
    wht_d  = wht_q;
    tint_d = tint_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegBlackRed:   blk_d[ChanRed]   = cfg_data_i[7:0];
        RegBlackGreen: blk_d[ChanGreen] = cfg_data_i[7:0];
        RegBlackBlue:  blk_d[ChanBlue]  = cfg_data_i[7:0];
        RegWhiteRed:   wht_d[ChanRed]   = cfg_data_i[7:0];
        RegWhiteGreen: wht_d[ChanGreen] = cfg_data_i[7:0];
        RegWhiteBlue:  wht_d[ChanBlue]  = cfg_data_i[7:0];
        RegTintAmount: tint_d           = cfg_data_i;
        default: ;     // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_q            <= {NumChan{BlackRst}};
      wht_q[ChanRed]   <= WhiteRedRst;
      wht_q[ChanGreen] <= WhiteGreenRst;
      wht_q[ChanBlue]  <= WhiteBlueRst;
      tint_q           <= TintRst;
    end else begin
      blk_q  <= blk_d;
      wht_q  <= wht_d;
      tint_q <= tint_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Valid line and sideband line; valid bits travel with the data
  // ---------------------------------------------------------------------------
  logic [NumStages-1:0] vld_q, vld_d;
  pix_t                 pix_q [NumStages-1];
  pix_t                 pix_in;

  assign pix_in.col[ChanBlue]  = in_blue_i;
  assign pix_in.col[ChanGreen] = in_green_i;
  assign pix_in.col[ChanRed]   = in_red_i;
  assign pix_in.alpha          = in_alpha_i;
  assign pix_in.frame_end      = in_frame_end_i;

  assign vld_d = {vld_q[NumStages-2:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // advance the sideband every cycle; a bubble carries don't-care data
  always_ff @(posedge clk_i) begin
    pix_q[0] <= pix_in;
    for (int s = 1; s < NumStages - 1; s++) begin
      pix_q[s] <= pix_q[s-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: luma weight products
  // ---------------------------------------------------------------------------
  logic [23:0] lp_b_q, lp_g_q, lp_r_q;

  always_ff @(posedge clk_i) begin
    lp_b_q <= 24'(LumaWb) * 24'(in_blue_i);
    lp_g_q <= 24'(LumaWg) * 24'(in_green_i);
    lp_r_q <= 24'(LumaWr) * 24'(in_red_i);
  end

  // ---------------------------------------------------------------------------
  // Stage 2: luma sum and gradient spans W-K
  // ---------------------------------------------------------------------------
  logic [23:0]                    luma_sum;
  logic [7:0]                     luma_q;
  logic signed [NumChan-1:0][8:0] span_d, span_q;

  assign luma_sum = lp_b_q + lp_g_q + lp_r_q;  // weights sum to 2^16, no overflow

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      span_d[c] = 9'({1'b0, wht_q[c]}) - 9'({1'b0, blk_q[c]});
    end
  end

  always_ff @(posedge clk_i) begin
    luma_q <= luma_sum[23:16];
    span_q <= span_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: gradient product Y*(W-K), fits 17 bits signed
  // ---------------------------------------------------------------------------
  logic signed [NumChan-1:0][16:0] gp_d, gp_q;

  always_comb begin
    logic signed [18:0] full;
    full = '0;
    for (int c = 0; c < NumChan; c++) begin
      full    = $signed({2'b00, luma_q}) * $signed(span_q[c]);
      gp_d[c] = full[16:0];
    end
  end

  always_ff @(posedge clk_i) begin
    gp_q <= gp_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: divide by 255 toward zero on the magnitude, then restore sign.
  // For x below 65535, x/255 = ((x+1) + ((x+1) >> 8)) >> 8.
  // ---------------------------------------------------------------------------
  logic signed [NumChan-1:0][8:0] quo_d, quo_q;

  always_comb begin
    logic        neg;
    logic [16:0] mag;
    logic [16:0] inc;
    logic [16:0] acc;
    logic [8:0]  q9;
    neg = 1'b0;
    mag = '0;
    inc = '0;
    acc = '0;
    q9  = '0;
    for (int c = 0; c < NumChan; c++) begin
      neg      = gp_q[c][16];
      mag      = neg ? (17'd0 - gp_q[c]) : gp_q[c];
      inc      = mag + 17'd1;
      acc      = inc + (inc >> 8);
      q9       = {1'b0, acc[15:8]};
      quo_d[c] = neg ? (9'd0 - q9) : q9;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: mapped colour M = K + quotient, clamped; effective amount
  // ---------------------------------------------------------------------------
  logic [NumChan-1:0][7:0] map_d, map_q;
  logic [8:0]              amt_d, amt_q;

  always_comb begin
    logic [9:0] sum10;
    sum10 = '0;
    for (int c = 0; c < NumChan; c++) begin
      sum10 = {2'b00, blk_q[c]} + {quo_q[c][8], quo_q[c]};
      if (sum10[9]) begin
        map_d[c] = 8'd0;
      end else if (sum10[8]) begin
        map_d[c] = 8'd255;
      end else begin
        map_d[c] = sum10[7:0];
      end
    end
    // hold amounts above full at full
    amt_d = (tint_q > AmountFull) ? AmountFull : tint_q;
  end

  always_ff @(posedge clk_i) begin
    map_q <= map_d;
    amt_q <= amt_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 6: blend products (256-A)*C and A*M
  // ---------------------------------------------------------------------------
  logic [NumChan-1:0][16:0] bs_d, bs_q;
  logic [NumChan-1:0][16:0] bm_d, bm_q;
  logic [8:0]               inv_amt;

  assign inv_amt = AmountFull - amt_q;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      bs_d[c] = 17'(inv_amt) * 17'(pix_q[4].col[c]);
      bm_d[c] = 17'(amt_q) * 17'(map_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    bs_q <= bs_d;
    bm_q <= bm_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 7: blend sum, shift, saturate into the output register
  // ---------------------------------------------------------------------------
  logic [NumChan-1:0][7:0] res_d, res_q;

  always_comb begin
    logic [16:0] bsum;
    bsum = '0;
    for (int c = 0; c < NumChan; c++) begin
      bsum     = bs_q[c] + bm_q[c];
      res_d[c] = bsum[16] ? 8'd255 : bsum[15:8];
    end
  end

  logic [7:0] alpha_q;
  logic       fend_q;

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    alpha_q <= pix_q[5].alpha;
    fend_q  <= pix_q[5].frame_end;
  end

  assign out_valid_o     = vld_q[NumStages-1];
  assign out_blue_o      = res_q[ChanBlue];
  assign out_green_o     = res_q[ChanGreen];
  assign out_red_o       = res_q[ChanRed];
  assign out_alpha_o     = alpha_q;
  assign out_frame_end_o = fend_q;

endmodule

// ----- verif/lgt_pixel_checker.sv -----
// Scoreboard for luma_gradient_tint_pixel_core: mirrors the config registers,
// predicts each tinted pixel and compares it with the strobed result beat.
// Depends on lgt_pkg for register indexes and channel numbers.
module lgt_pixel_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [7:0]                   in_blue_i,
  input  logic [7:0]                   in_green_i,
  input  logic [7:0]                   in_red_i,
  input  logic [7:0]                   in_alpha_i,
  input  logic                         in_frame_end_i,
  input  logic                         cfg_we_i,
  input  logic [lgt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lgt_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         out_valid_i,
  input  logic [7:0]                   out_blue_i,
  input  logic [7:0]                   out_green_i,
  input  logic [7:0]                   out_red_i,
  input  logic [7:0]                   out_alpha_i,
  input  logic                         out_frame_end_i,
  output int                           mismatch_count_o,
  output int                           pending_o
);
  import lgt_pkg::*;

  // Q16 luma weights and Q8 full tint
  localparam int WeightBlue = 7471;
  localparam int WeightGreen = 38470;
  localparam int WeightRed = 19595;
  localparam int FullTint = 256;

  typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       frame_end;
  } tinted_pix_t;

  logic [7:0]  black_lvl [NumChan];
  logic [7:0]  white_lvl [NumChan];
  logic [8:0]  tint_amt;
  tinted_pix_t tinted_q [$];
  int          mismatches = 0;

  // Point on the black-to-white gradient; the quotient truncates toward zero
  function automatic logic [7:0] gradient_level(int luma, logic [7:0] k, logic [7:0] w);
    int span;
    int m;
    span = int'(w) - int'(k);
    m = int'(k) + (luma * span) / 255;
    if (m < 0) m = 0;
    if (m > 255) m = 255;
    return m[7:0];
  endfunction

  function automatic logic [7:0] blend_level(logic [7:0] c, logic [7:0] m, int amt);
    int v;
    v = ((FullTint - amt) * int'(c) + amt * int'(m)) >> 8;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic tinted_pix_t tint_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                             logic [7:0] alpha, logic fe);
    tinted_pix_t p;
    int luma;
    int amt;
    // amounts above full clamp to the mapped colour alone
    amt = (int'(tint_amt) > FullTint) ? FullTint : int'(tint_amt);
    luma = (WeightBlue * int'(b) + WeightGreen * int'(g) + WeightRed * int'(r)) >> 16;
    p.blue = blend_level(b, gradient_level(luma, black_lvl[ChanBlue], white_lvl[ChanBlue]), amt);
    p.green = blend_level(g, gradient_level(luma, black_lvl[ChanGreen], white_lvl[ChanGreen]),
                          amt);
    p.red = blend_level(r, gradient_level(luma, black_lvl[ChanRed], white_lvl[ChanRed]), amt);
    p.alpha = alpha;
    p.frame_end = fe;
    return p;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tinted_pix_t want;
    if (!rst_ni) begin
      black_lvl[ChanRed] = BlackRst;
      black_lvl[ChanGreen] = BlackRst;
      black_lvl[ChanBlue] = BlackRst;
      white_lvl[ChanRed] = WhiteRedRst;
      white_lvl[ChanGreen] = WhiteGreenRst;
      white_lvl[ChanBlue] = WhiteBlueRst;
      tint_amt = TintRst;
      tinted_q.delete();
    end else begin
      // predict with the settings in force before this edge
      if (start_i && !busy_i) begin
        tinted_q.push_back(tint_pixel(in_blue_i, in_green_i, in_red_i, in_alpha_i,
                                      in_frame_end_i));
      end
      if (out_valid_i) begin
        if (tinted_q.size() == 0) begin
          $display("%0t: result beat expected none, got b=%0d g=%0d r=%0d a=%0d fe=%0d",
                   $time, out_blue_i, out_green_i, out_red_i, out_alpha_i, out_frame_end_i);
          mismatches++;
        end else begin
          want = tinted_q.pop_front();
          check_field("out_blue", want.blue, out_blue_i);
          check_field("out_green", want.green, out_green_i);
          check_field("out_red", want.red, out_red_i);
          check_field("out_alpha", want.alpha, out_alpha_i);
          check_field("out_frame_end", want.frame_end, out_frame_end_i);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegBlackRed:   black_lvl[ChanRed] = cfg_data_i[7:0];
          RegBlackGreen: black_lvl[ChanGreen] = cfg_data_i[7:0];
          RegBlackBlue:  black_lvl[ChanBlue] = cfg_data_i[7:0];
          RegWhiteRed:   white_lvl[ChanRed] = cfg_data_i[7:0];
          RegWhiteGreen: white_lvl[ChanGreen] = cfg_data_i[7:0];
          RegWhiteBlue:  white_lvl[ChanBlue] = cfg_data_i[7:0];
          RegTintAmount: tint_amt = cfg_data_i;
          default: begin
          end
        endcase
      end
    end
    pending_o = tinted_q.size();
    mismatch_count_o = mismatches;
  end

endmodule

// ----- verif/tb_luma_gradient_tint_pixel_core.sv -----
// Testbench top for luma_gradient_tint_pixel_core: drives pixel beats and
// register writes through several gradient settings and gives the verdict.
// Depends on lgt_pkg and lgt_pixel_checker, which predicts and compares.
module tb_luma_gradient_tint_pixel_core;
  import lgt_pkg::*;

  // Index past the last register; writes to it must be dropped
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  // Cycles with no beat in either direction before the run is abandoned
  localparam int QuietLimit = 500;
  localparam int NumPhases = 10;
  localparam int PixelsPerPhase = 55;

  // Directed pixels: black, white, each primary alone, near-extremes, mid grey.
  // Packed eight bytes per field, entry i at [i*8 +: 8].
  localparam int NumDirected = 8;
  localparam logic [63:0] DirBlue  = {8'd128, 8'd254, 8'd1,   8'd0,   8'd0,   8'd255, 8'd255, 8'd0};
  localparam logic [63:0] DirGreen = {8'd128, 8'd1,   8'd254, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0};
  localparam logic [63:0] DirRed   = {8'd128, 8'd254, 8'd1,   8'd255, 8'd0,   8'd0,   8'd255, 8'd0};
  localparam logic [63:0] DirAlpha = {8'haa,  8'h55,  8'hfe,  8'h01,  8'h7f,  8'h80,  8'hff,  8'h00};
  localparam logic [7:0]  DirFend  = 8'b1001_0010;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic [7:0]           in_blue_i = '0;
  logic [7:0]           in_green_i = '0;
  logic [7:0]           in_red_i = '0;
  logic [7:0]           in_alpha_i = '0;
  logic                 in_frame_end_i = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;
  logic                 busy_o;
  logic                 out_valid_o;
  logic [7:0]           out_blue_o;
  logic [7:0]           out_green_o;
  logic [7:0]           out_red_o;
  logic [7:0]           out_alpha_o;
  logic                 out_frame_end_o;

  int mismatch_count;
  int pixels_pending;
  int quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  luma_gradient_tint_pixel_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .in_blue_i       (in_blue_i),
    .in_green_i      (in_green_i),
    .in_red_i        (in_red_i),
    .in_alpha_i      (in_alpha_i),
    .in_frame_end_i  (in_frame_end_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_blue_o      (out_blue_o),
    .out_green_o     (out_green_o),
    .out_red_o       (out_red_o),
    .out_alpha_o     (out_alpha_o),
    .out_frame_end_o (out_frame_end_o)
  );

  lgt_pixel_checker u_tint_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .in_blue_i        (in_blue_i),
    .in_green_i       (in_green_i),
    .in_red_i         (in_red_i),
    .in_alpha_i       (in_alpha_i),
    .in_frame_end_i   (in_frame_end_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_i      (out_valid_o),
    .out_blue_i       (out_blue_o),
    .out_green_i      (out_green_o),
    .out_red_i        (out_red_o),
    .out_alpha_i      (out_alpha_o),
    .out_frame_end_i  (out_frame_end_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pixels_pending)
  );

  // Watchdog: restart on any accepted beat, abandon the run after a long silence
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || out_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Hold one pixel on the ports until a beat is taken, then maybe idle a while.
  // An idle gap follows gap_pct percent of beats; 50 gives about half
  // the cycles idle, 11 about a fifth.
  task automatic push_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                            input logic [7:0] alpha, input logic fe, input int gap_pct);
    logic taken;
    start_i <= 1'b1;
    in_blue_i <= b;
    in_green_i <= g;
    in_red_i <= r;
    in_alpha_i <= alpha;
    in_frame_end_i <= fe;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end
    if ($urandom_range(1, 100) <= gap_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Load a full gradient setting, plus a junk write to the unused index
  task automatic program_gradient(input logic [7:0] kr, input logic [7:0] kg,
                                  input logic [7:0] kb, input logic [7:0] wr,
                                  input logic [7:0] wg, input logic [7:0] wb,
                                  input logic [8:0] tint);
    write_reg(RegBlackRed, {1'b0, kr});
    write_reg(RegBlackGreen, {1'b0, kg});
    write_reg(RegBlackBlue, {1'b0, kb});
    write_reg(RegWhiteRed, {1'b0, wr});
    write_reg(RegWhiteGreen, {1'b0, wg});
    write_reg(RegWhiteBlue, {1'b0, wb});
    write_reg(RegTintAmount, tint);
    write_reg(RegUnused, CfgDataW'($urandom_range(0, 511)));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for every outstanding pixel, then let the pipeline settle
  task automatic drain_pipeline();
    do @(negedge clk_i); while (pixels_pending != 0);
    repeat (NumStages + 2) @(posedge clk_i);
  endtask

  task automatic push_directed(input int gap_pct);
    for (int i = 0; i < NumDirected; i++) begin
      push_pixel(DirBlue[i*8 +: 8], DirGreen[i*8 +: 8], DirRed[i*8 +: 8],
                 DirAlpha[i*8 +: 8], DirFend[i], gap_pct);
    end
  endtask

  // Mostly uniform levels, with the rails hit now and then
  function automatic logic [7:0] pick_level();
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [8:0] pick_tint();
    if ($urandom_range(0, 3) == 0) return 9'($urandom_range(257, 511));
    return 9'($urandom_range(0, 256));
  endfunction

  initial begin
    int gap_pct;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings first, no idling
    push_directed(0);
    start_i <= 1'b0;

    for (int p = 0; p < NumPhases; p++) begin
      drain_pipeline();
      case (p)
        // black brighter than white: the gradient runs downward, full tint
        0: program_gradient(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 9'd256);
        // zero tint passes the source through
        1: program_gradient(pick_level(), pick_level(), pick_level(),
                            pick_level(), pick_level(), pick_level(), 9'd0);
        // amount above full clamps to the mapped colour
        2: program_gradient(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 9'd511);
        3: program_gradient(pick_level(), pick_level(), pick_level(),
                            pick_level(), pick_level(), pick_level(), 9'd300);
        default: program_gradient(pick_level(), pick_level(), pick_level(),
                                  pick_level(), pick_level(), pick_level(), pick_tint());
      endcase
      gap_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 50 : 11;
      if (p == 0 || p == 2) push_directed(gap_pct);
      repeat (PixelsPerPhase) begin
        push_pixel(pick_level(), pick_level(), pick_level(), 8'($urandom_range(0, 255)),
                   ($urandom_range(0, 15) == 0), gap_pct);
      end
      start_i <= 1'b0;
    end

    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/lgt_pkg.sv
src/luma_gradient_tint_pixel_core.sv
verif/lgt_pixel_checker.sv
verif/tb_luma_gradient_tint_pixel_core.sv
